// ----- rtl/ppsla_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppsla_pkg
// Shared types and constants of the pad port serial link adapter.
// ----------------------------------------------------------------------------
package ppsla_pkg;

  localparam int QUEUE_DEPTH  = 16;
  localparam int BUTTON_COUNT = 12;
  localparam int BYTE_W       = 8;
  localparam int PAD_W        = 5;
  localparam int PHASE_W      = 4;
  localparam int PTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int BTN_IDX_W    = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;

  localparam logic [PAD_W-1:0]   PAD_END         = PAD_W'(16);
  localparam logic [PHASE_W-1:0] PHASE_IDLE      = PHASE_W'(0);
  localparam logic [PHASE_W-1:0] PHASE_START     = PHASE_W'(1);
  localparam logic [PHASE_W-1:0] PHASE_LAST_DATA = PHASE_W'(8);

  localparam logic [1:0] OP_PULSE   = 2'd0;
  localparam logic [1:0] OP_LATCH   = 2'd1;
  localparam logic [1:0] OP_HOST_WR = 2'd2;
  localparam logic [1:0] OP_HOST_RD = 2'd3;

  typedef struct packed {
    logic [1:0]              op;
    logic [BYTE_W-1:0]       value;
    logic                    io_line;
    logic [BUTTON_COUNT-1:0] pad_buttons;
  } in_t;

  typedef struct packed {
    logic [1:0]        line_bits;
    logic [BYTE_W-1:0] host_byte_out;
    logic              host_byte_valid;
    logic              host_data_waiting;
    logic              overflow_flag;
  } out_t;

endpackage

// ----- rtl/pad_port_serial_link_adapter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pad_port_serial_link_adapter
// Game-pad port adapter: pad shift mode and bit-serial link to a host, with
// one byte queue in RAM for each direction.
// ----------------------------------------------------------------------------
// Pipeline: an accepted transaction is registered in stage s1, then in the output
// register once that is free. One transaction per cycle while the output is not
// stalled; queue pointers and serial state update at the accept edge, and a host
// read's RAM data is registered alongside s1. Reset: synchronous, clears engines,
// queue pointers and the pipeline; queue RAM contents are not cleared.
// ----------------------------------------------------------------------------
module pad_port_serial_link_adapter (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_wdata,
  input  logic             in_valid,
  output logic             in_stall,
  input  ppsla_pkg::in_t   in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output ppsla_pkg::out_t  out_data
);

  logic                               cfg_second_r;
  logic [ppsla_pkg::PAD_W-1:0]        pad_count_r, pad_count_nxt;
  logic                               latch_r, latch_nxt;
  logic [ppsla_pkg::PHASE_W-1:0]      send_phase_r, send_phase_nxt;
  logic [ppsla_pkg::BYTE_W-1:0]       send_shift_r, send_shift_nxt, send_sh_eff;
  logic                               send_pend_r, send_pend_nxt;
  logic [ppsla_pkg::PHASE_W-1:0]      recv_phase_r, recv_phase_nxt;
  logic [ppsla_pkg::BYTE_W-1:0]       recv_shift_r, recv_shift_nxt;
  logic                               first_bit_r, first_bit_nxt;
  logic [ppsla_pkg::PTR_W-1:0]        hq_head_r, hq_head_nxt, hq_tail_r, hq_tail_nxt;
  logic [ppsla_pkg::CNT_W-1:0]        hq_cnt_r, hq_cnt_nxt;
  logic [ppsla_pkg::PTR_W-1:0]        cq_head_r, cq_head_nxt, cq_tail_r, cq_tail_nxt;
  logic [ppsla_pkg::CNT_W-1:0]        cq_cnt_r, cq_cnt_nxt;

  logic                               hq_we, hq_re, cq_we, cq_re;
  logic [ppsla_pkg::BYTE_W-1:0]       hq_rdata, cq_rdata, cq_wdata;

  logic                               s1_v_r, s1_v_nxt;
  ppsla_pkg::out_t                    s1_r, s1_nxt;
  logic                               out_v_r, out_v_nxt;
  ppsla_pkg::out_t                    out_r, out_nxt;

  logic in_acc, s1_move;

  localparam logic [ppsla_pkg::CNT_W-1:0] QFULL = ppsla_pkg::CNT_W'(ppsla_pkg::QUEUE_DEPTH);
  localparam logic [ppsla_pkg::PTR_W-1:0] QLAST =
    ppsla_pkg::PTR_W'(ppsla_pkg::QUEUE_DEPTH - 1);
  localparam logic [ppsla_pkg::PAD_W-1:0] BTN_END =
    ppsla_pkg::PAD_W'(ppsla_pkg::BUTTON_COUNT);

  function automatic logic [ppsla_pkg::PTR_W-1:0] ptr_inc(
    input logic [ppsla_pkg::PTR_W-1:0] p
  );
    return (p == QLAST) ? '0 : p + ppsla_pkg::PTR_W'(1);
  endfunction

  assign s1_move  = s1_v_r & (~out_v_r | ~out_stall);
  assign in_stall = s1_v_r & ~s1_move;
  assign in_acc   = in_valid & ~in_stall;

  assign send_sh_eff = send_pend_r ? cq_rdata : send_shift_r;
  assign cq_wdata    = ~in_data.value;

  always_comb begin
    pad_count_nxt  = pad_count_r;
    latch_nxt      = latch_r;
    send_phase_nxt = send_phase_r;
    send_shift_nxt = send_sh_eff;
    send_pend_nxt  = 1'b0;
    recv_phase_nxt = recv_phase_r;
    recv_shift_nxt = recv_shift_r;
    first_bit_nxt  = first_bit_r;
    hq_head_nxt    = hq_head_r;
    hq_tail_nxt    = hq_tail_r;
    hq_cnt_nxt     = hq_cnt_r;
    cq_head_nxt    = cq_head_r;
    cq_tail_nxt    = cq_tail_r;
    cq_cnt_nxt     = cq_cnt_r;
    hq_we          = 1'b0;
    hq_re          = 1'b0;
    cq_we          = 1'b0;
    cq_re          = 1'b0;
    s1_nxt         = '0;
    if (in_acc) begin
      case (in_data.op)
        ppsla_pkg::OP_PULSE: begin
          if (in_data.io_line) begin
            if (pad_count_r >= ppsla_pkg::PAD_END) begin
              s1_nxt.line_bits = 2'b01;
            end else begin
              if (pad_count_r < BTN_END) begin
                s1_nxt.line_bits =
                  {1'b0, in_data.pad_buttons[pad_count_r[ppsla_pkg::BTN_IDX_W-1:0]]};
              end
              if (!latch_r) begin
                pad_count_nxt = pad_count_r + ppsla_pkg::PAD_W'(1);
              end
            end
          end else begin
            if (recv_phase_r == ppsla_pkg::PHASE_IDLE) begin
              if (!latch_r) begin
                recv_phase_nxt = ppsla_pkg::PHASE_START;
              end
            end else if (recv_phase_r <= ppsla_pkg::PHASE_LAST_DATA) begin
              recv_shift_nxt = {latch_r, recv_shift_r[ppsla_pkg::BYTE_W-1:1]};
              recv_phase_nxt = recv_phase_r + ppsla_pkg::PHASE_W'(1);
            end else begin
              if (latch_r) begin
                if (hq_cnt_r == QFULL) begin
                  s1_nxt.overflow_flag = 1'b1;
                end else begin
                  hq_we       = 1'b1;
                  hq_tail_nxt = ptr_inc(hq_tail_r);
                  hq_cnt_nxt  = hq_cnt_r + ppsla_pkg::CNT_W'(1);
                end
              end
              recv_phase_nxt = ppsla_pkg::PHASE_IDLE;
            end
            if (send_phase_r == ppsla_pkg::PHASE_IDLE && cq_cnt_r != '0) begin
              cq_re          = 1'b1;
              cq_head_nxt    = ptr_inc(cq_head_r);
              cq_cnt_nxt     = cq_cnt_r - ppsla_pkg::CNT_W'(1);
              send_pend_nxt  = 1'b1;
              first_bit_nxt  = 1'b1;
              send_phase_nxt = ppsla_pkg::PHASE_START;
            end else if (send_phase_r <= ppsla_pkg::PHASE_LAST_DATA) begin
              first_bit_nxt  = send_sh_eff[0];
              send_shift_nxt = {1'b0, send_sh_eff[ppsla_pkg::BYTE_W-1:1]};
              send_phase_nxt = send_phase_r + ppsla_pkg::PHASE_W'(1);
            end else begin
              first_bit_nxt  = 1'b0;
              send_phase_nxt = ppsla_pkg::PHASE_IDLE;
            end
            s1_nxt.line_bits = {cfg_second_r, first_bit_nxt};
          end
        end
        ppsla_pkg::OP_LATCH: begin
          if (in_data.value[0] != latch_r) begin
            latch_nxt     = in_data.value[0];
            pad_count_nxt = '0;
          end
        end
        ppsla_pkg::OP_HOST_WR: begin
          if (cq_cnt_r == QFULL) begin
            s1_nxt.overflow_flag = 1'b1;
          end else begin
            cq_we       = 1'b1;
            cq_tail_nxt = ptr_inc(cq_tail_r);
            cq_cnt_nxt  = cq_cnt_r + ppsla_pkg::CNT_W'(1);
          end
        end
        ppsla_pkg::OP_HOST_RD: begin
          if (hq_cnt_r != '0) begin
            hq_re                  = 1'b1;
            hq_head_nxt            = ptr_inc(hq_head_r);
            hq_cnt_nxt             = hq_cnt_r - ppsla_pkg::CNT_W'(1);
            s1_nxt.host_byte_valid = 1'b1;
          end
        end
        default: begin
        end
      endcase
      s1_nxt.host_data_waiting = (hq_cnt_nxt != '0);
    end
  end

  always_comb begin
    out_nxt               = s1_r;
    out_nxt.host_byte_out = s1_r.host_byte_valid ? hq_rdata : '0;
  end

  assign s1_v_nxt  = in_acc | (s1_v_r & ~s1_move);
  assign out_v_nxt = s1_move | (out_v_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_second_r <= 1'b0;
      pad_count_r  <= '0;
      latch_r      <= 1'b0;
      send_phase_r <= '0;
      send_shift_r <= '0;
      send_pend_r  <= 1'b0;
      recv_phase_r <= '0;
      recv_shift_r <= '0;
      first_bit_r  <= 1'b0;
      hq_head_r    <= '0;
      hq_tail_r    <= '0;
      hq_cnt_r     <= '0;
      cq_head_r    <= '0;
      cq_tail_r    <= '0;
      cq_cnt_r     <= '0;
      s1_v_r       <= 1'b0;
      out_v_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        cfg_second_r <= cfg_wdata;
      end
      pad_count_r  <= pad_count_nxt;
      latch_r      <= latch_nxt;
      send_phase_r <= send_phase_nxt;
      send_shift_r <= send_shift_nxt;
      send_pend_r  <= send_pend_nxt;
      recv_phase_r <= recv_phase_nxt;
      recv_shift_r <= recv_shift_nxt;
      first_bit_r  <= first_bit_nxt;
      hq_head_r    <= hq_head_nxt;
      hq_tail_r    <= hq_tail_nxt;
      hq_cnt_r     <= hq_cnt_nxt;
      cq_head_r    <= cq_head_nxt;
      cq_tail_r    <= cq_tail_nxt;
      cq_cnt_r     <= cq_cnt_nxt;
      s1_v_r       <= s1_v_nxt;
      out_v_r      <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= s1_nxt;
    end
    if (s1_move) begin
      out_r <= out_nxt;
    end
  end

  ppsla_ram #(
    .WIDTH (ppsla_pkg::BYTE_W),
    .DEPTH (ppsla_pkg::QUEUE_DEPTH)
  ) u_host_q (
    .clk   (clk),
    .we    (hq_we),
    .waddr (hq_tail_r),
    .wdata (recv_shift_r),
    .re    (hq_re),
    .raddr (hq_head_r),
    .rdata (hq_rdata)
  );

  ppsla_ram #(
    .WIDTH (ppsla_pkg::BYTE_W),
    .DEPTH (ppsla_pkg::QUEUE_DEPTH)
  ) u_cons_q (
    .clk   (clk),
    .we    (cq_we),
    .waddr (cq_tail_r),
    .wdata (cq_wdata),
    .re    (cq_re),
    .raddr (cq_head_r),
    .rdata (cq_rdata)
  );

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

// ----- rtl/ppsla_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppsla_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ppsla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/ppsla_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppsla_checker
// Port-level assertions for the pad port serial link adapter.
// ----------------------------------------------------------------------------
module ppsla_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_stall,
  input ppsla_pkg::in_t  in_data,
  input logic            out_valid,
  input logic            out_stall,
  input ppsla_pkg::out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output transaction changed");

  a_accept_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> ##2 out_valid)
    else $error("accepted transaction did not reach the output");

  a_empty_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.host_byte_valid |-> out_data.host_byte_out == '0)
    else $error("host byte without a valid read");

  a_stall_only_when_out_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with the output stage free");

endmodule

bind pad_port_serial_link_adapter ppsla_checker u_ppsla_checker (.*);

// ----- bench/pad_port_serial_link_adapter_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pad_port_serial_link_adapter_test
// Self-checking bench for the pad port serial link adapter. A scoreboard model
// of the pad shifter, the bit-serial receiver and sender and both byte queues
// predicts every output transaction. Stimulus runs a short directed sequence,
// then random mixes of serial frames, some with a bad stop bit, pad reads, host
// accesses and noise. The final phase floods both queues until they overflow.
// Both sides idle at random, and a long receiver hold-off backs up the input.
// ----------------------------------------------------------------------------
module pad_port_serial_link_adapter_test;
  import ppsla_pkg::*;

  localparam int CLK_HALF    = 2;
  localparam int CYCLE_LIMIT = 100000;
  localparam int HOLD_CYCLES = 80;
  localparam int HOLD_DELAY  = 30;
  localparam int SETTLE      = 4;
  localparam int MIX_ITEMS   = 60;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  pad_port_serial_link_adapter u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // scoreboard model state
  int                pad_cnt = 0;
  logic              latch_lvl = 1'b0;
  int                rx_phase = 0;
  logic [BYTE_W-1:0] rx_shift = '0;
  int                tx_phase = 0;
  logic [BYTE_W-1:0] tx_shift = '0;
  logic              tx_line = 1'b0;
  logic              line2_level = 1'b0;
  logic [BYTE_W-1:0] to_host_bytes[$];
  logic [BYTE_W-1:0] to_console_bytes[$];

  in_t  pending_items[$];
  out_t expected_outputs[$];

  // stimulus-side tracking of latch and receiver phase, for frame alignment
  logic gen_latch = 1'b0;
  int   gen_rx_phase = 0;
  int   items_added = 0;

  int   snd_idle = 0;
  int   rcv_idle = 0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int   hold_wait = 0;
  int   hold_left = 0;
  int   n_driven = 0;

  int   errors = 0;
  int   cycles = 0;
  int   n_accepted = 0;
  int   n_checked = 0;
  int   n_overflows = 0;
  int   n_host_bytes = 0;
  int   n_cfg_writes = 0;

  function automatic out_t next_port_output(in_t it);
    out_t r;
    r = '0;
    case (it.op)
      OP_PULSE: begin
        if (it.io_line) begin
          if (pad_cnt >= int'(PAD_END)) begin
            r.line_bits = 2'b01;
          end else begin
            if (pad_cnt < BUTTON_COUNT) begin
              r.line_bits = {1'b0, it.pad_buttons[BTN_IDX_W'(pad_cnt)]};
            end
            if (!latch_lvl) pad_cnt++;
          end
        end else begin
          if (rx_phase == 0) begin
            if (!latch_lvl) rx_phase = 1;
          end else if (rx_phase <= 8) begin
            rx_shift = {latch_lvl, rx_shift[BYTE_W-1:1]};
            rx_phase++;
          end else begin
            if (latch_lvl) begin
              if (to_host_bytes.size() >= QUEUE_DEPTH) r.overflow_flag = 1'b1;
              else to_host_bytes.push_back(rx_shift);
            end
            rx_phase = 0;
          end
          if (tx_phase == 0 && to_console_bytes.size() != 0) begin
            tx_shift = to_console_bytes.pop_front();
            tx_line  = 1'b1;
            tx_phase = 1;
          end else if (tx_phase <= 8) begin
            tx_line  = tx_shift[0];
            tx_shift = tx_shift >> 1;
            tx_phase++;
          end else begin
            tx_line  = 1'b0;
            tx_phase = 0;
          end
          r.line_bits = {line2_level, tx_line};
        end
      end
      OP_LATCH: begin
        if (it.value[0] != latch_lvl) begin
          latch_lvl = it.value[0];
          pad_cnt   = 0;
        end
      end
      OP_HOST_WR: begin
        if (to_console_bytes.size() >= QUEUE_DEPTH) r.overflow_flag = 1'b1;
        else to_console_bytes.push_back(~it.value);
      end
      default: begin
        if (to_host_bytes.size() != 0) begin
          r.host_byte_out   = to_host_bytes.pop_front();
          r.host_byte_valid = 1'b1;
        end
      end
    endcase
    r.host_data_waiting = (to_host_bytes.size() != 0);
    return r;
  endfunction

  function automatic void check_field(string fname, logic [BYTE_W-1:0] want,
                                      logic [BYTE_W-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, fname, want, got);
    end
  endfunction

  function automatic logic [BYTE_W-1:0] rand_byte();
    return BYTE_W'($urandom);
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom);
  endfunction

  function automatic logic [BUTTON_COUNT-1:0] rand_buttons();
    return BUTTON_COUNT'($urandom);
  endfunction

  // stimulus builders
  function automatic void add_item(logic [1:0] op, logic [BYTE_W-1:0] val, logic io,
                                   logic [BUTTON_COUNT-1:0] btn);
    in_t it;
    it.op          = op;
    it.value       = val;
    it.io_line     = io;
    it.pad_buttons = btn;
    pending_items.push_back(it);
    items_added++;
    if (op == OP_LATCH) begin
      gen_latch = val[0];
    end else if (op == OP_PULSE && !io) begin
      if (gen_rx_phase == 0) begin
        if (!gen_latch) gen_rx_phase = 1;
      end else if (gen_rx_phase <= 8) begin
        gen_rx_phase++;
      end else begin
        gen_rx_phase = 0;
      end
    end
  endfunction

  function automatic void set_latch(logic lv);
    if (gen_latch != lv) begin
      add_item(OP_LATCH, (rand_byte() & 8'hfe) | {7'd0, lv}, rand_bit(), rand_buttons());
    end
  endfunction

  function automatic void serial_pulse();
    add_item(OP_PULSE, rand_byte(), 1'b0, rand_buttons());
  endfunction

  function automatic void host_access(logic reads_ok);
    if (reads_ok && $urandom_range(1) != 0) begin
      add_item(OP_HOST_RD, rand_byte(), rand_bit(), rand_buttons());
    end else begin
      add_item(OP_HOST_WR, rand_byte(), rand_bit(), rand_buttons());
    end
  endfunction

  function automatic void add_frame(logic good_stop, logic reads_ok);
    logic [BYTE_W-1:0] frame_val;
    frame_val = rand_byte();
    if (gen_rx_phase != 0) begin
      set_latch(1'b1);
      while (gen_rx_phase != 0) serial_pulse();
    end
    set_latch(1'b0);
    serial_pulse();
    for (int i = 0; i < 8; i++) begin
      if ($urandom_range(9) == 0) host_access(reads_ok);
      set_latch(frame_val[i]);
      serial_pulse();
    end
    set_latch(good_stop);
    serial_pulse();
  endfunction

  function automatic void add_pad_read();
    int n;
    set_latch(1'b1);
    set_latch(1'b0);
    n = $urandom_range(12, 20);
    repeat (n) add_item(OP_PULSE, rand_byte(), 1'b1, rand_buttons());
    if ($urandom_range(3) == 0) begin
      set_latch(1'b1);
      repeat ($urandom_range(1, 3)) add_item(OP_PULSE, rand_byte(), 1'b1, rand_buttons());
    end
  endfunction

  function automatic void add_random_mix(int n_items);
    int start;
    int pick;
    start = items_added;
    while (items_added - start < n_items) begin
      pick = $urandom_range(99);
      if (pick < 40) add_frame($urandom_range(9) != 0, 1'b1);
      else if (pick < 55) add_pad_read();
      else if (pick < 70) repeat ($urandom_range(1, 3)) host_access(1'b0);
      else if (pick < 85) repeat ($urandom_range(1, 3))
        add_item(OP_HOST_RD, rand_byte(), rand_bit(), rand_buttons());
      else add_item(2'($urandom_range(3)), rand_byte(), rand_bit(), rand_buttons());
    end
  endfunction

  task automatic drain();
    while (pending_items.size() != 0 || n_accepted != n_driven ||
           expected_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_level(logic lv);
    @(negedge clk);
    cfg_we      <= 1'b1;
    cfg_wdata   <= lv;
    line2_level = lv;
    n_cfg_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // input driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (n_accepted == n_driven) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= snd_idle) begin
        in_valid <= 1'b1;
        in_data  <= pending_items.pop_front();
        n_driven++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output stall, with one long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_req && !hold_done && hold_wait == HOLD_DELAY) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      if (hold_req && !hold_done) hold_wait++;
      out_stall <= ($urandom_range(99) < rcv_idle);
    end
  end

  // monitor: check results, then record accepted transactions
  always @(posedge clk) begin
    out_t want;
    if (rst_n) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d results outstanding", cycles,
                 expected_outputs.size());
        $display("** pad_port_serial_link_adapter: FAILED **");
        $finish;
      end else begin
        if (out_valid && !out_stall) begin
          if (expected_outputs.size() == 0) begin
            errors++;
            $display("%0t ns: result with none expected, expected none actual %p",
                     $time, out_data);
          end else begin
            want = expected_outputs.pop_front();
            n_checked++;
            check_field("line_bits", BYTE_W'(want.line_bits), BYTE_W'(out_data.line_bits));
            check_field("host_byte_out", want.host_byte_out, out_data.host_byte_out);
            check_field("host_byte_valid", BYTE_W'(want.host_byte_valid),
                        BYTE_W'(out_data.host_byte_valid));
            check_field("host_data_waiting", BYTE_W'(want.host_data_waiting),
                        BYTE_W'(out_data.host_data_waiting));
            check_field("overflow_flag", BYTE_W'(want.overflow_flag),
                        BYTE_W'(out_data.overflow_flag));
          end
        end
        if (in_valid && !in_stall) begin
          want = next_port_output(in_data);
          if (want.overflow_flag) n_overflows++;
          if (want.host_byte_valid) n_host_bytes++;
          expected_outputs.push_back(want);
          n_accepted++;
        end
      end
    end
  end

  // test sequence
  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: pad bits, empty read, extreme bytes, one clean frame
    write_level(1'b0);
    snd_idle = 23;
    rcv_idle = 68;
    add_item(OP_LATCH, 8'h00, 1'b0, 12'h000);
    add_item(OP_HOST_RD, 8'hff, 1'b1, 12'hfff);
    add_item(OP_PULSE, 8'h00, 1'b1, 12'hfff);
    add_item(OP_PULSE, 8'hff, 1'b1, 12'h000);
    add_item(OP_HOST_WR, 8'h00, 1'b0, 12'h000);
    add_item(OP_HOST_WR, 8'hff, 1'b0, 12'hfff);
    repeat (9) add_item(OP_PULSE, 8'h00, 1'b0, 12'hfff);
    add_item(OP_LATCH, 8'hff, 1'b0, 12'h000);
    add_item(OP_PULSE, 8'h00, 1'b0, 12'h000);
    add_item(OP_HOST_RD, 8'h00, 1'b0, 12'h000);
    add_item(OP_PULSE, 8'h00, 1'b1, 12'habc);
    add_item(OP_LATCH, 8'h00, 1'b1, 12'h000);
    drain();

    // random mix, second line high, with a long output hold-off
    write_level(1'b1);
    hold_req = 1'b1;
    add_random_mix(MIX_ITEMS);
    drain();

    // random mix, idling swapped
    write_level(1'b0);
    snd_idle = 68;
    rcv_idle = 23;
    add_random_mix(MIX_ITEMS);
    drain();

    // flood both queues past full, then read the host queue dry
    write_level(1'b1);
    snd_idle = 0;
    rcv_idle = 0;
    repeat (QUEUE_DEPTH + 2) add_item(OP_HOST_WR, rand_byte(), rand_bit(), rand_buttons());
    repeat (QUEUE_DEPTH + 1) add_frame(1'b1, 1'b0);
    repeat (QUEUE_DEPTH + 4) add_item(OP_HOST_RD, rand_byte(), rand_bit(), rand_buttons());
    drain();

    $display("checked %0d of %0d transactions over %0d register writes", n_checked,
             n_accepted, n_cfg_writes);
    $display("%0d host bytes read back, %0d queue overflows, %0d mismatches",
             n_host_bytes, n_overflows, errors);
    if (errors == 0 && expected_outputs.size() == 0) begin
      $display("** pad_port_serial_link_adapter: PASSED **");
    end else begin
      $display("** pad_port_serial_link_adapter: FAILED **");
    end
    $finish;
  end

endmodule
